>>> rtl/teq_pkg.sv
package teq_pkg;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_ADD_ONE  = 3'd1,
        OP_ADD_PER  = 3'd2,
        OP_START    = 3'd3,
        OP_STOP     = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_FIRED    = 3'd2,
        ST_NONE_DUE = 3'd3,
        ST_CTRL     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_LAST,
        S_FIRE_RD,
        S_FIRE,
        S_DONE
    } state_t;

    localparam int unsigned TIME_W = 48;
    localparam int unsigned DLY_W  = 32;
    localparam int unsigned TAG_W  = 16;

    typedef logic [TIME_W-1:0] time_t;

    function automatic time_t sat_add(input time_t a, input logic [DLY_W-1:0] b);
        logic [TIME_W:0] s;
        begin
            s = {1'b0, a} + {{(TIME_W+1-DLY_W){1'b0}}, b};
            sat_add = s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
        end
    endfunction

endpackage

>>> rtl/timed_event_queue.sv
// Timed event queue over one entry memory (deadline, period, tag, kind).
// Add, start, stop: one result from the done state; free-slot search runs on valid bits.
// Running tick: a memory scan of all slots, then a fire read and fire step per firing,
// then a closing scan and the done state, or the done state alone at the cap.
// Each firing result is held until the next fire or done state shows if it ends the tick.
// Results appear one cycle each on done; the receiver cannot stall. Reset clears valid bits.
module timed_event_queue #(
    parameter int TASK_SLOTS         = 16,
    parameter int MAX_FIRES_PER_TICK = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [47:0] now_time,
    input  logic [31:0] delay,
    input  logic [15:0] task_tag,
    output logic        done,
    output logic [2:0]  status,
    output logic [15:0] fired_tag,
    output logic        last
);

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int FW = $clog2(MAX_FIRES_PER_TICK + 1);
    localparam int EW = teq_pkg::TIME_W + teq_pkg::DLY_W + teq_pkg::TAG_W + 1;

    teq_pkg::state_t state_reg, state_next;

    logic [TASK_SLOTS-1:0] valid_reg;
    logic                  running_reg;
    logic [2:0]            op_reg;
    teq_pkg::time_t        now_reg;
    logic [IW-1:0]         idx_reg;
    logic                  found_reg;
    logic [IW-1:0]         best_reg;
    teq_pkg::time_t        best_dl_reg;
    logic [FW-1:0]         fires_reg;
    logic [15:0]           fire_tag_reg;

    // entry memory
    logic [EW-1:0]  mem [TASK_SLOTS];
    logic [EW-1:0]  rd_data;
    logic           we;
    logic [IW-1:0]  waddr, raddr;
    logic [EW-1:0]  wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data <= mem[raddr];
    end

    teq_pkg::time_t      rd_dl;
    logic [31:0]         rd_per;
    logic [15:0]         rd_tag;
    logic                rd_periodic;
    assign {rd_dl, rd_per, rd_tag, rd_periodic} = rd_data;

    // slot whose data sits on rd_data during scan
    logic [IW-1:0] rd_idx_reg;

    // lowest free slot
    logic          free_any;
    logic [IW-1:0] free_idx;
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    logic [31:0] per_in;
    assign per_in = (opcode == teq_pkg::OP_ADD_PER && delay == '0) ? 32'd1 : delay;

    logic is_add;
    assign is_add = (opcode == teq_pkg::OP_ADD_ONE) || (opcode == teq_pkg::OP_ADD_PER);

    logic cand;
    assign cand = valid_reg[rd_idx_reg] && (rd_dl <= now_reg)
                  && (!found_reg || rd_dl < best_dl_reg);

    logic accept;
    assign accept = start && !busy;
    assign busy = (state_reg != teq_pkg::S_IDLE);

    logic scan_end;
    assign scan_end = (idx_reg == IW'(TASK_SLOTS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            teq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == teq_pkg::OP_TICK && running_reg)
                        state_next = teq_pkg::S_SCAN;
                    else
                        state_next = teq_pkg::S_DONE;
                end
            end
            teq_pkg::S_SCAN:      state_next = scan_end ? teq_pkg::S_SCAN_LAST : teq_pkg::S_SCAN;
            teq_pkg::S_SCAN_LAST: state_next = (found_reg || cand) ? teq_pkg::S_FIRE_RD
                                                                   : teq_pkg::S_DONE;
            teq_pkg::S_FIRE_RD:   state_next = teq_pkg::S_FIRE;
            teq_pkg::S_FIRE:      state_next = (fires_reg + FW'(1) == FW'(MAX_FIRES_PER_TICK))
                                               ? teq_pkg::S_DONE : teq_pkg::S_SCAN;
            teq_pkg::S_DONE:      state_next = teq_pkg::S_IDLE;
            default:              state_next = teq_pkg::S_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        we    = 1'b0;
        waddr = free_idx;
        wdata = {teq_pkg::sat_add(now_time, delay), per_in, task_tag,
                 opcode == teq_pkg::OP_ADD_PER};
        raddr = idx_reg;
        case (state_reg)
            teq_pkg::S_IDLE:
            begin
                we    = accept && is_add && free_any;
                raddr = '0;
            end
            teq_pkg::S_SCAN_LAST: raddr = best_reg;
            teq_pkg::S_FIRE_RD:   raddr = best_reg;
            teq_pkg::S_FIRE:
            begin
                we    = rd_periodic;
                waddr = best_reg;
                wdata = {teq_pkg::sat_add(rd_dl, rd_per), rd_per, rd_tag, rd_periodic};
                raddr = '0;
            end
            default: ;
        endcase
        if (state_reg == teq_pkg::S_SCAN_LAST && cand)
            raddr = rd_idx_reg;
    end

    // result outputs
    always_comb
    begin
        done      = 1'b0;
        status    = teq_pkg::ST_CTRL;
        fired_tag = '0;
        last      = 1'b1;
        case (state_reg)
            teq_pkg::S_FIRE:
            begin
                // release the previous firing; another one follows it
                done      = (fires_reg != '0);
                status    = teq_pkg::ST_FIRED;
                fired_tag = fire_tag_reg;
                last      = 1'b0;
            end
            teq_pkg::S_DONE:
            begin
                done = 1'b1;
                case (op_reg)
                    teq_pkg::OP_TICK:
                    begin
                        if (fires_reg != '0)
                        begin
                            status    = teq_pkg::ST_FIRED;
                            fired_tag = fire_tag_reg;
                        end
                        else
                            status = teq_pkg::ST_NONE_DUE;
                    end
                    teq_pkg::OP_ADD_ONE, teq_pkg::OP_ADD_PER:
                        status = found_reg ? teq_pkg::ST_ACCEPTED : teq_pkg::ST_FULL;
                    default: status = teq_pkg::ST_CTRL;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= teq_pkg::S_IDLE;
            valid_reg    <= '0;
            running_reg  <= 1'b0;
            fires_reg    <= '0;
            found_reg    <= 1'b0;
            op_reg       <= '0;
            now_reg      <= '0;
            idx_reg      <= '0;
            best_reg     <= '0;
            best_dl_reg  <= '0;
            fire_tag_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                teq_pkg::S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= opcode;
                        now_reg   <= now_time;
                        idx_reg   <= '0;
                        fires_reg <= '0;
                        found_reg <= is_add && free_any;
                        if (is_add && free_any)
                            valid_reg[free_idx] <= 1'b1;
                        if (opcode == teq_pkg::OP_START)
                            running_reg <= 1'b1;
                        if (opcode == teq_pkg::OP_STOP)
                        begin
                            if (running_reg)
                                valid_reg <= '0;
                            running_reg <= 1'b0;
                        end
                    end
                end
                teq_pkg::S_SCAN:
                begin
                    if (idx_reg != '0 && cand)
                    begin
                        found_reg   <= 1'b1;
                        best_reg    <= rd_idx_reg;
                        best_dl_reg <= rd_dl;
                    end
                    idx_reg <= scan_end ? idx_reg : idx_reg + IW'(1);
                end
                teq_pkg::S_SCAN_LAST:
                begin
                    if (cand)
                    begin
                        found_reg <= 1'b1;
                        best_reg  <= rd_idx_reg;
                    end
                end
                teq_pkg::S_FIRE:
                begin
                    fires_reg    <= fires_reg + FW'(1);
                    fire_tag_reg <= rd_tag;
                    found_reg    <= 1'b0;
                    idx_reg      <= '0;
                    if (!rd_periodic)
                        valid_reg[best_reg] <= 1'b0;
                end
                teq_pkg::S_DONE:
                begin
                    found_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // address of the slot returned by the read issued last cycle
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= raddr;
    end

endmodule

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = 16;
    localparam int MAX_FIRES = 64;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  op;
        logic [47:0] now;
        logic [31:0] dly;
        logic [15:0] tag;
    } request_t;

    typedef struct packed {
        logic [2:0]  st;
        logic [15:0] tag;
        logic        fin;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  opcode;
    logic [47:0] now_time;
    logic [31:0] delay;
    logic [15:0] task_tag;
    logic        done;
    logic [2:0]  status;
    logic [15:0] fired_tag;
    logic        last;

    timed_event_queue i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .now_time(now_time), .delay(delay), .task_tag(task_tag),
        .done(done), .status(status), .fired_tag(fired_tag), .last(last)
    );

    // shadow of the queue
    logic [47:0] q_deadline [SLOTS];
    logic [31:0] q_period   [SLOTS];
    logic [15:0] q_tag      [SLOTS];
    logic        q_valid    [SLOTS];
    logic        q_periodic [SLOTS];
    logic        q_running;

    request_t pending_reqs[$];
    outcome_t expected_outcomes[$];
    int       errors;
    bit       stim_done;
    bit       drain_hold;
    int       gap_left;
    int       burst_left;

    function automatic logic [47:0] add_sat48(logic [47:0] a, logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? TIME_MAX : s[47:0];
    endfunction

    function automatic void predict_queue(request_t r);
        int n;
        int best;
        bit placed;
        n = 0;
        placed = 0;
        case (r.op)
            teq_pkg::OP_TICK:
            begin
                if (q_running)
                begin
                    while (n < MAX_FIRES)
                    begin
                        best = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (q_valid[i] && q_deadline[i] <= r.now &&
                                (best < 0 || q_deadline[i] < q_deadline[best]))
                                best = i;
                        if (best < 0)
                            break;
                        expected_outcomes.push_back('{teq_pkg::ST_FIRED, q_tag[best], 1'b0});
                        n++;
                        if (q_periodic[best])
                            q_deadline[best] = add_sat48(q_deadline[best], q_period[best]);
                        else
                            q_valid[best] = 0;
                    end
                end
                if (n == 0)
                    expected_outcomes.push_back('{teq_pkg::ST_NONE_DUE, 16'd0, 1'b1});
                else
                    expected_outcomes[$].fin = 1'b1;
            end
            teq_pkg::OP_ADD_ONE, teq_pkg::OP_ADD_PER:
            begin
                for (int i = 0; i < SLOTS && !placed; i++)
                begin
                    if (!q_valid[i])
                    begin
                        q_deadline[i] = add_sat48(r.now, r.dly);
                        q_period[i]   = (r.op == teq_pkg::OP_ADD_PER && r.dly == 0)
                                        ? 32'd1 : r.dly;
                        q_tag[i]      = r.tag;
                        q_periodic[i] = (r.op == teq_pkg::OP_ADD_PER);
                        q_valid[i]    = 1;
                        placed = 1;
                    end
                end
                expected_outcomes.push_back('{placed ? teq_pkg::ST_ACCEPTED : teq_pkg::ST_FULL,
                                              16'd0, 1'b1});
            end
            default:
            begin
                if (r.op == teq_pkg::OP_START)
                    q_running = 1;
                else if (r.op == teq_pkg::OP_STOP)
                begin
                    if (q_running)
                        for (int i = 0; i < SLOTS; i++)
                            q_valid[i] = 0;
                    q_running = 0;
                end
                expected_outcomes.push_back('{teq_pkg::ST_CTRL, 16'd0, 1'b1});
            end
        endcase
    endfunction

    function automatic void queue_req(logic [2:0] op, logic [47:0] now, logic [31:0] dly,
                                      logic [15:0] tag);
        pending_reqs.push_back('{op, now, dly, tag});
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[47:0];
    endfunction

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        logic [47:0] t;
        int k;
        errors = 0;
        stim_done = 0;
        drain_hold = 0;
        q_running = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            q_valid[i] = 0;
            q_deadline[i] = 0;
            q_period[i] = 0;
            q_tag[i] = 0;
            q_periodic[i] = 0;
        end
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;

        // directed
        queue_req(teq_pkg::OP_TICK, 48'd0, 32'd0, 16'd0);          // tick while stopped
        queue_req(teq_pkg::OP_STOP, 48'd0, 32'd0, 16'd0);          // stop while stopped
        queue_req(teq_pkg::OP_ADD_ONE, 48'd10, 32'd5, 16'hFFFF);   // add while stopped
        queue_req(teq_pkg::OP_ADD_PER, 48'd10, 32'd0, 16'h1234);   // zero period
        queue_req(teq_pkg::OP_ADD_ONE, 48'd15, 32'd0, 16'h0001);   // equal deadline
        queue_req(teq_pkg::OP_START, 48'd0, 32'd0, 16'd0);
        queue_req(teq_pkg::OP_TICK, 48'd5, 32'd0, 16'd0);          // nothing due
        queue_req(teq_pkg::OP_TICK, 48'd80, 32'd0, 16'd0);         // hits the firing cap
        queue_req(teq_pkg::OP_ADD_ONE, TIME_MAX, 32'hFFFF_FFFF, 16'hABCD); // saturation
        queue_req(teq_pkg::OP_ADD_PER, TIME_MAX - 3, 32'hFFFF_FFFF, 16'h5555);
        for (int i = 0; i < 15; i++)
            queue_req(teq_pkg::OP_ADD_ONE, 48'd0, 32'd3, 16'(i));  // fill then overflow
        queue_req(3'd5, 48'd0, 32'd0, 16'd0);
        queue_req(3'd7, rand48(), $urandom(), 16'($urandom()));
        queue_req(teq_pkg::OP_TICK, TIME_MAX, 32'd0, 16'd0);
        queue_req(teq_pkg::OP_STOP, 48'd0, 32'd0, 16'd0);

        // random: mostly adds and ticks on a rising clock, a few controls
        t = 0;
        k = 0;
        while (k < 420)
        begin
            int dice;
            dice = $urandom_range(99);
            if (dice < 4)
            begin
                queue_req(teq_pkg::OP_START, rand48(), $urandom(), 16'($urandom()));
                k++;
            end
            else if (dice < 6)
            begin
                queue_req(teq_pkg::OP_STOP, rand48(), $urandom(), 16'($urandom()));
                k++;
            end
            else if (dice < 8)
            begin
                queue_req(3'($urandom_range(7)), rand48(), $urandom(), 16'($urandom()));
                k++;
            end
            else if (dice < 12)
            begin
                queue_req(3'($urandom_range(2)), rand48(), $urandom(), 16'($urandom()));
                k++;
            end
            else if (dice < 55)
            begin
                queue_req(3'($urandom_range(teq_pkg::OP_ADD_PER, teq_pkg::OP_ADD_ONE)), t,
                          ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(40)),
                          16'($urandom()));
                k++;
            end
            else
            begin
                t = t + $urandom_range(30);
                queue_req(teq_pkg::OP_TICK, t, $urandom(), 16'($urandom()));
                k++;
            end
            if (k == 200)
                queue_req(teq_pkg::OP_START, 48'd0, 32'd0, 16'd0);
        end

        // wait until every request is sent, accepted and answered
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || start || expected_outcomes.size() != 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_outcomes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("status: fail");
        $finish;
    end

    // driver: bursts with gaps, and one pause to drain mid-run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 0;
            opcode <= '0;
            now_time <= '0;
            delay <= '0;
            task_tag <= '0;
            gap_left <= 0;
            burst_left <= 4;
        end
        else if (start && busy)
        begin
            // hold the request
        end
        else
        begin
            if (start)
                predict_queue('{opcode, now_time, delay, task_tag});
            if (pending_reqs.size() == 210 && !drain_hold && expected_outcomes.size() != 0)
                start <= 0;
            else if (gap_left > 0)
            begin
                start <= 0;
                gap_left <= gap_left - 1;
            end
            else if (pending_reqs.size() != 0)
            begin
                request_t r;
                r = pending_reqs.pop_front();
                if (pending_reqs.size() == 209)
                    drain_hold <= 1;
                start <= 1;
                opcode <= r.op;
                now_time <= r.now;
                delay <= r.dly;
                task_tag <= r.tag;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(12);
                    gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(20);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                start <= 0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $error("unexpected result: status %0d tag %0h", status, fired_tag);
                errors++;
            end
            else
            begin
                outcome_t e;
                e = expected_outcomes.pop_front();
                if (status !== e.st)
                begin
                    $error("status: expected %0d actual %0d", e.st, status);
                    errors++;
                end
                if (fired_tag !== e.tag)
                begin
                    $error("fired_tag: expected %0h actual %0h", e.tag, fired_tag);
                    errors++;
                end
                if (last !== e.fin)
                begin
                    $error("last: expected %0d actual %0d", e.fin, last);
                    errors++;
                end
            end
        end
    end
endmodule
